// ----- rtl/core/ppft_pkg.sv -----
// Shared types, constants and small decode functions of the pixel packet filter tagger.
package ppft_pkg;

  localparam int unsigned NSLOT      = 4;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned PKT_W      = 30;
  localparam int unsigned BCID_W     = 9;
  localparam int unsigned BCID_LSB   = 21;
  localparam int unsigned HITS_W     = 8;
  localparam int unsigned BODY_W     = 21;
  localparam int unsigned BODY_LSB   = 7;
  localparam int unsigned CHIP_W     = 4;
  localparam int unsigned SENS_W     = 2;
  localparam int unsigned ASIC_W     = 2;
  localparam int unsigned TAG_W      = 4;
  localparam int unsigned NSENS      = 4;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned OKCNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BCID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_INDEX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_WINDOW = 2'd2;

  localparam logic [BCID_W-1:0] TRAIN_WINDOW_RST = 9'd200;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef logic [PKT_W-1:0] pkt_t;

  typedef struct packed {
    logic                 new_file;
    logic [NSLOT-1:0]     parity_bits;
    pkt_t [NSLOT-1:0]     pkt;
  } frame_t;

  typedef struct packed {
    logic [BCID_W-1:0] target;
    logic [BCID_W-1:0] bound;
    logic [SENS_W-1:0] sensor;
    logic [TAG_W-1:0]  tag;
  } cfg_t;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] tag_word;
    logic [CNT_W-1:0] hits;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [NSLOT-1:0]   emit;
    logic [NSLOT-1:0]   last;
    logic [OKCNT_W-1:0] ok_cnt;
    logic               stop;
    res_t [NSLOT-1:0]   res;
  } eval_t;

  // Sensor of a chip: chip/3, with the unused chip codes folded onto sensor 0.
  function automatic logic [SENS_W-1:0] chip_sensor(input logic [CHIP_W-1:0] chip);
    logic [SENS_W-1:0] s;
    unique case (chip)
      4'd0, 4'd1, 4'd2:   s = 2'd0;
      4'd3, 4'd4, 4'd5:   s = 2'd1;
      4'd6, 4'd7, 4'd8:   s = 2'd2;
      4'd9, 4'd10, 4'd11: s = 2'd3;
      default:            s = 2'd0;
    endcase
    return s;
  endfunction

  // ASIC within the sensor: chip%3.
  function automatic logic [ASIC_W-1:0] chip_asic(input logic [CHIP_W-1:0] chip);
    logic [ASIC_W-1:0] a;
    unique case (chip)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: a = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       a = 2'd1;
      default:                              a = 2'd2;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/ppft_in_if.sv -----
// Input frame channel: valid/ready handshake with four packets, parity bits and new-file flag.
interface ppft_in_if;
  logic                         valid;
  logic                         ready;
  logic                         new_file;
  logic [ppft_pkg::NSLOT-1:0]   parity_bits;
  logic [ppft_pkg::PKT_W-1:0]   packet_slot0;
  logic [ppft_pkg::PKT_W-1:0]   packet_slot1;
  logic [ppft_pkg::PKT_W-1:0]   packet_slot2;
  logic [ppft_pkg::PKT_W-1:0]   packet_slot3;

  modport source (
    output valid, new_file, parity_bits,
    output packet_slot0, packet_slot1, packet_slot2, packet_slot3,
    input  ready
  );
  modport sink (
    input  valid, new_file, parity_bits,
    input  packet_slot0, packet_slot1, packet_slot2, packet_slot3,
    output ready
  );
endinterface

// ----- rtl/core/ppft_out_if.sv -----
// Result channel: valid/ready handshake with one tagged packet result per transfer.
interface ppft_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [ppft_pkg::OUT_W-1:0]    tagged_packet;
  logic [ppft_pkg::SLOT_W-1:0]   slot;
  logic [ppft_pkg::CNT_W-1:0]    sensor_hits;
  logic                          last;

  modport source (
    output valid, status, tagged_packet, slot, sensor_hits, last,
    input  ready
  );
  modport sink (
    input  valid, status, tagged_packet, slot, sensor_hits, last,
    output ready
  );
endinterface

// ----- rtl/core/ppft_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and write data.
interface ppft_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppft_pkg::CFG_IDX_W-1:0]  index;
  logic [ppft_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ppft_cfg_regs.sv -----
// Configuration registers and the decoded crossing bound, sensor and chip tag.
module ppft_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  ppft_cfg_if.sink         cfg_ch,
  output ppft_pkg::cfg_t   cfg
);

  logic [ppft_pkg::BCID_W-1:0] target_r;
  logic [ppft_pkg::CHIP_W-1:0] chip_r;
  logic [ppft_pkg::BCID_W-1:0] window_r;
  logic [ppft_pkg::SENS_W-1:0] sensor;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      chip_r   <= '0;
      window_r <= ppft_pkg::TRAIN_WINDOW_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        ppft_pkg::CFG_TARGET_BCID:  target_r <= cfg_ch.data[ppft_pkg::BCID_W-1:0];
        ppft_pkg::CFG_CHIP_INDEX:   chip_r   <= cfg_ch.data[ppft_pkg::CHIP_W-1:0];
        ppft_pkg::CFG_TRAIN_WINDOW: window_r <= cfg_ch.data[ppft_pkg::BCID_W-1:0];
        default: ;
      endcase
    end
  end

  // The bound wraps at the crossing id width.
  assign sensor     = ppft_pkg::chip_sensor(chip_r);
  assign cfg.target = target_r;
  assign cfg.bound  = target_r + window_r;
  assign cfg.sensor = sensor;
  assign cfg.tag    = {sensor, ppft_pkg::chip_asic(chip_r)};

endmodule

// ----- rtl/core/ppft_eval.sv -----
// Single-pass evaluation of one frame: filter, stop chain, parity check and result build.
module ppft_eval (
  input  ppft_pkg::frame_t          frame,
  input  ppft_pkg::cfg_t            cfg,
  input  logic                      stopped,
  input  logic [ppft_pkg::CNT_W-1:0] base,
  output ppft_pkg::eval_t           ev
);

  always_comb begin
    logic                          alive;
    logic [ppft_pkg::OKCNT_W-1:0]  cnt;
    logic [ppft_pkg::BCID_W-1:0]   bcid;
    logic                          nonempty;
    logic                          fail;
    ev    = '0;
    cnt   = '0;
    alive = !(stopped && !frame.new_file);
    for (int s = 0; s < ppft_pkg::NSLOT; s++) begin
      bcid     = frame.pkt[s][ppft_pkg::PKT_W-1:ppft_pkg::BCID_LSB];
      nonempty = |frame.pkt[s][ppft_pkg::HITS_W-1:0];
      fail     = (^frame.pkt[s]) != frame.parity_bits[ppft_pkg::NSLOT-1-s];
      if (alive && nonempty) begin
        if (bcid >= cfg.bound) begin
          alive = 1'b0;
        end else if (bcid == cfg.target) begin
          ev.emit[s] = 1'b1;
          if (fail) begin
            ev.res[s].status   = ppft_pkg::STATUS_FAIL;
            ev.res[s].tag_word = '0;
          end else begin
            cnt                = cnt + ppft_pkg::OKCNT_W'(1);
            ev.res[s].status   = ppft_pkg::STATUS_OK;
            ev.res[s].tag_word = {cfg.tag, frame.pkt[s][ppft_pkg::BODY_W-1:0],
                                  ppft_pkg::BODY_LSB'(0)};
          end
          ev.res[s].hits = base + ppft_pkg::CNT_W'(cnt);
        end
      end
    end
    ev.stop   = !alive;
    ev.ok_cnt = cnt;
    for (int s = 0; s < ppft_pkg::NSLOT; s++) begin
      ev.last[s]     = ev.emit[s] && ((ev.emit >> (s + 1)) == '0);
      ev.res[s].last = ev.last[s];
    end
  end

endmodule

// ----- rtl/core/pixel_packet_filter_tagger_core.sv -----
// Top level of the pixel packet filter tagger: frame register, result bundle and output stage.
// A frame of four packets is taken into a frame register and evaluated in one pass; its up to
// four results go into a bundle register that drains one result transfer per cycle into the
// output register while the receiver does not stall. A new frame can be taken into the frame
// register while the results of the previous frame still drain, and it moves on into the
// bundle once the bundle empties, so the single result port sets the rate of frames. The first
// result of a frame is presented from the output register after the frame has passed the
// frame register and the bundle register. The stop flag and the four per-sensor hit counters
// advance when a frame leaves the frame register, so the next frame always sees the state
// that the previous one left. Configuration writes are taken at any time and are expected
// only while no frame is in flight.
module pixel_packet_filter_tagger_core (
  input  logic        clk,
  input  logic        rst_n,
  ppft_in_if.sink     in_ch,
  ppft_out_if.source  out_ch,
  ppft_cfg_if.sink    cfg_ch
);

  ppft_pkg::cfg_t   cfg;
  ppft_pkg::eval_t  ev;
  ppft_pkg::frame_t in_frame;

  // Frame register: holds the frame being evaluated.
  logic             a_valid_r;
  logic             a_valid_nxt;
  ppft_pkg::frame_t frame_r;

  // Architectural state.
  logic                                         stopped_r;
  logic [ppft_pkg::NSENS-1:0][ppft_pkg::CNT_W-1:0] hits_r;

  // Result bundle: one entry per slot with a pending-result mask.
  logic [ppft_pkg::NSLOT-1:0]                   b_mask_r;
  logic [ppft_pkg::NSLOT-1:0]                   b_mask_nxt;
  ppft_pkg::res_t [ppft_pkg::NSLOT-1:0]         b_res_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  ppft_pkg::res_t                out_res_r;
  logic [ppft_pkg::SLOT_W-1:0]   out_slot_r;

  logic                          in_acc;
  logic                          out_load;
  logic [ppft_pkg::NSLOT-1:0]    pop_oh;
  logic [ppft_pkg::SLOT_W-1:0]   pop_idx;
  logic [ppft_pkg::NSLOT-1:0]    b_rem;
  logic                          a_move;

  ppft_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ppft_eval u_eval (
    .frame   (frame_r),
    .cfg     (cfg),
    .stopped (stopped_r),
    .base    (hits_r[cfg.sensor]),
    .ev      (ev)
  );

  assign in_frame.new_file    = in_ch.new_file;
  assign in_frame.parity_bits = in_ch.parity_bits;
  assign in_frame.pkt[0]      = in_ch.packet_slot0;
  assign in_frame.pkt[1]      = in_ch.packet_slot1;
  assign in_frame.pkt[2]      = in_ch.packet_slot2;
  assign in_frame.pkt[3]      = in_ch.packet_slot3;

  // The output register can take a new result when it is empty or being drained.
  assign out_load = !out_valid_r || out_ch.ready;

  // Results leave the bundle in slot order: lowest pending slot first.
  always_comb begin
    pop_oh  = '0;
    pop_idx = '0;
    if (out_load) begin
      for (int s = ppft_pkg::NSLOT - 1; s >= 0; s--) begin
        if (b_mask_r[s]) begin
          pop_oh    = '0;
          pop_oh[s] = 1'b1;
          pop_idx   = ppft_pkg::SLOT_W'(s);
        end
      end
    end
  end

  // The evaluated frame moves into the bundle once the bundle empties in this cycle.
  assign b_rem       = b_mask_r & ~pop_oh;
  assign a_move      = a_valid_r && (b_rem == '0);
  assign in_ch.ready = !a_valid_r || a_move;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign a_valid_nxt   = in_acc ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
  assign b_mask_nxt    = a_move ? ev.emit : b_rem;
  assign out_valid_nxt = out_load ? (|b_mask_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_mask_r    <= '0;
      out_valid_r <= 1'b0;
      stopped_r   <= 1'b0;
      hits_r      <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_mask_r    <= b_mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_move) begin
        stopped_r          <= ev.stop;
        hits_r[cfg.sensor] <= hits_r[cfg.sensor] + ppft_pkg::CNT_W'(ev.ok_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame_r <= in_frame;
    end
    if (a_move) begin
      b_res_r <= ev.res;
    end
    if (out_load && (|b_mask_r)) begin
      out_res_r  <= b_res_r[pop_idx];
      out_slot_r <= pop_idx;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.tagged_packet = out_res_r.tag_word;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.sensor_hits   = out_res_r.hits;
  assign out_ch.last          = out_res_r.last;

  // A stopped train without a new-file mark produces no results.
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && stopped_r && !frame_r.new_file |-> ev.emit == '0)
    else $error("stopped frame produced results");

  // A failed parity check carries an all-zero packet field.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == ppft_pkg::STATUS_FAIL) |-> out_res_r.tag_word == '0)
    else $error("failure result with nonzero packet");

  // State advances only when a frame leaves the frame register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !a_move |=> $stable(hits_r) && $stable(stopped_r))
    else $error("state changed without a frame move");

  // A frame with results marks exactly one of them as its last.
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && (ev.emit != '0) |-> $onehot(ev.last))
    else $error("frame does not have exactly one last result");

endmodule

// ----- tb/ppft_tag_checker.sv -----
// Checker of the pixel packet filter tagger: mirrors the filter state and compares every result.
module ppft_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  ppft_in_if          in_ch,
  ppft_out_if         out_ch,
  ppft_cfg_if         cfg_ch,
  output int unsigned err_cnt,
  output int unsigned pending_cnt,
  output int unsigned frame_cnt,
  output int unsigned result_cnt,
  output int unsigned fail_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        status;
    logic [ppft_pkg::OUT_W-1:0]  tag_word;
    logic [ppft_pkg::SLOT_W-1:0] slot;
    logic [ppft_pkg::CNT_W-1:0]  hits;
    logic                        last;
  } tag_result_t;

  // Mirror of the block's registers and state.
  logic [ppft_pkg::BCID_W-1:0] keep_bcid;
  logic [ppft_pkg::CHIP_W-1:0] chip_sel;
  logic [ppft_pkg::BCID_W-1:0] train_span;
  logic                        stopped;
  logic [ppft_pkg::CNT_W-1:0]  hit_tab [ppft_pkg::NSENS];

  tag_result_t due_results[$];

  int unsigned errs     = 0;
  int unsigned due_cnt  = 0;
  int unsigned frames   = 0;
  int unsigned results  = 0;
  int unsigned failures = 0;

  assign err_cnt     = errs;
  assign pending_cnt = due_cnt;
  assign frame_cnt   = frames;
  assign result_cnt  = results;
  assign fail_cnt    = failures;

  // Walks the four slots in order and queues the results that the frame causes.
  task automatic predict_frame(input logic nf, input logic [ppft_pkg::NSLOT-1:0] par,
                               input ppft_pkg::pkt_t p0, input ppft_pkg::pkt_t p1,
                               input ppft_pkg::pkt_t p2, input ppft_pkg::pkt_t p3);
    ppft_pkg::pkt_t              pk [ppft_pkg::NSLOT];
    tag_result_t                 got [ppft_pkg::NSLOT];
    logic [ppft_pkg::SENS_W-1:0] sens;
    logic [ppft_pkg::ASIC_W-1:0] asic;
    logic [ppft_pkg::TAG_W-1:0]  tag;
    logic [ppft_pkg::BCID_W-1:0] bound;
    logic [ppft_pkg::BCID_W-1:0] bcid;
    int                          n;
    logic                        halt;
    pk[0] = p0;
    pk[1] = p1;
    pk[2] = p2;
    pk[3] = p3;
    sens  = (chip_sel < 4'd12) ? ppft_pkg::SENS_W'(chip_sel / 4'd3) : '0;
    asic  = ppft_pkg::ASIC_W'(chip_sel % 4'd3);
    tag   = {sens, asic};
    bound = keep_bcid + train_span;
    if (nf) stopped = 1'b0;
    n    = 0;
    halt = 1'b0;
    for (int s = 0; s < ppft_pkg::NSLOT; s++) begin
      bcid = pk[s][ppft_pkg::PKT_W-1:ppft_pkg::BCID_LSB];
      if (stopped) halt = 1'b1;
      if (!halt && pk[s][ppft_pkg::HITS_W-1:0] != '0) begin
        if (bcid >= bound) begin
          stopped = 1'b1;
          halt    = 1'b1;
        end else if (bcid == keep_bcid) begin
          got[n].slot = ppft_pkg::SLOT_W'(s);
          got[n].last = 1'b0;
          if ((^pk[s]) != par[ppft_pkg::NSLOT-1-s]) begin
            got[n].status   = ppft_pkg::STATUS_FAIL;
            got[n].tag_word = '0;
          end else begin
            hit_tab[sens]   = hit_tab[sens] + 1'b1;
            got[n].status   = ppft_pkg::STATUS_OK;
            got[n].tag_word = {tag, pk[s][ppft_pkg::BODY_W-1:0],
                               {ppft_pkg::BODY_LSB{1'b0}}};
          end
          got[n].hits = hit_tab[sens];
          n++;
        end
      end
    end
    if (n > 0) got[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) due_results = {due_results, got[k]};
    frames++;
  endtask

  function automatic int field_mismatch(input string name, input logic [31:0] want_v,
                                        input logic [31:0] seen_v);
    if (seen_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, seen_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    tag_result_t want;
    int          bad;
    if (!rst_n) begin
      keep_bcid  = '0;
      chip_sel   = '0;
      train_span = ppft_pkg::TRAIN_WINDOW_RST;
      stopped    = 1'b0;
      for (int k = 0; k < ppft_pkg::NSENS; k++) hit_tab[k] = '0;
      due_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          ppft_pkg::CFG_TARGET_BCID:  keep_bcid  = cfg_ch.data[ppft_pkg::BCID_W-1:0];
          ppft_pkg::CFG_CHIP_INDEX:   chip_sel   = cfg_ch.data[ppft_pkg::CHIP_W-1:0];
          ppft_pkg::CFG_TRAIN_WINDOW: train_span = cfg_ch.data[ppft_pkg::BCID_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_frame(in_ch.new_file, in_ch.parity_bits, in_ch.packet_slot0,
                      in_ch.packet_slot1, in_ch.packet_slot2, in_ch.packet_slot3);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %h packet %h",
                   $time, out_ch.status, out_ch.tagged_packet);
          $display("%0t: slot %h hits %h last %h", $time, out_ch.slot,
                   out_ch.sensor_hits, out_ch.last);
          errs++;
        end else begin
          want = due_results.pop_front();
          bad  = 0;
          bad += field_mismatch("status", 32'(want.status), 32'(out_ch.status));
          bad += field_mismatch("tagged_packet", want.tag_word, out_ch.tagged_packet);
          bad += field_mismatch("slot", 32'(want.slot), 32'(out_ch.slot));
          bad += field_mismatch("sensor_hits", want.hits, out_ch.sensor_hits);
          bad += field_mismatch("last", 32'(want.last), 32'(out_ch.last));
          if (bad != 0) errs++;
          results++;
          if (want.status == ppft_pkg::STATUS_FAIL) failures++;
        end
      end
    end
    due_cnt <= due_results.size();
  end

endmodule

// ----- tb/tb_pixel_packet_filter_tagger_core.sv -----
// Testbench top of the pixel packet filter tagger: clock, reset, stimulus and verdict.
module tb_pixel_packet_filter_tagger_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  ppft_in_if  in_ch();
  ppft_out_if out_ch();
  ppft_cfg_if cfg_ch();

  int unsigned err_cnt;
  int unsigned pending_cnt;
  int unsigned frame_cnt;
  int unsigned result_cnt;
  int unsigned fail_cnt;

  // Idle percentages of the sender and the receiver; changed between phases.
  int unsigned send_idle;
  int unsigned recv_idle;

  // Current register setting, kept here so that random frames can aim at the kept crossing
  // and at the train bound.
  logic [ppft_pkg::BCID_W-1:0] cur_target;
  logic [ppft_pkg::BCID_W-1:0] cur_bound;
  int unsigned                 setting_cnt;

  pixel_packet_filter_tagger_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ppft_tag_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .err_cnt     (err_cnt),
    .pending_cnt (pending_cnt),
    .frame_cnt   (frame_cnt),
    .result_cnt  (result_cnt),
    .fail_cnt    (fail_cnt)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // The receiver stalls at random; with recv_idle at zero it is always ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Builds a packet from its crossing id, address and hit pattern.
  function automatic ppft_pkg::pkt_t mk_pkt(input logic [ppft_pkg::BCID_W-1:0] bcid,
                                            input logic [12:0] addr,
                                            input logic [ppft_pkg::HITS_W-1:0] hits);
    return {bcid, addr, hits};
  endfunction

  // Offers one frame and holds it until the block takes it. The parity bits are the correct
  // ones for each slot, inverted where flip has a one, so a frame can carry parity failures on
  // chosen slots. Random idle cycles are inserted before the frame is offered.
  task automatic send_frame(input logic nf, input logic [ppft_pkg::NSLOT-1:0] flip,
                            input ppft_pkg::pkt_t p0, input ppft_pkg::pkt_t p1,
                            input ppft_pkg::pkt_t p2, input ppft_pkg::pkt_t p3);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.new_file     <= nf;
    in_ch.parity_bits  <= {^p0, ^p1, ^p2, ^p3} ^ flip;
    in_ch.packet_slot0 <= p0;
    in_ch.packet_slot1 <= p1;
    in_ch.packet_slot2 <= p2;
    in_ch.packet_slot3 <= p3;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stops offering frames until the checker holds no expectation. The first edge lets the
  // checker count a frame that was taken at the edge on which this task is entered.
  task automatic wait_results_clear();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // A frame that causes no result may still sit in the frame register when the last result
  // has come, so a few more cycles pass before the block counts as idle.
  task automatic drain_block();
    wait_results_clear();
    repeat (12) @(posedge clk);
  endtask

  // One register write; the caller lowers valid after its last write so that valid stays
  // high across back-to-back writes.
  task automatic cfg_write(input logic [ppft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppft_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic set_config(input logic [ppft_pkg::BCID_W-1:0] tgt,
                            input logic [ppft_pkg::CHIP_W-1:0] chip,
                            input logic [ppft_pkg::BCID_W-1:0] win);
    drain_block();
    cfg_write(ppft_pkg::CFG_TARGET_BCID, ppft_pkg::CFG_DATA_W'(tgt));
    cfg_write(ppft_pkg::CFG_CHIP_INDEX, ppft_pkg::CFG_DATA_W'(chip));
    cfg_write(ppft_pkg::CFG_TRAIN_WINDOW, ppft_pkg::CFG_DATA_W'(win));
    cfg_ch.valid <= 1'b0;
    cur_target = tgt;
    cur_bound  = tgt + win;
    setting_cnt++;
  endtask

  // Random frame. Most frames are well formed: packets mostly of the kept crossing with
  // random addresses and hits, some empty, some of another crossing below the bound and a
  // few that reach the bound and stop the file. The rest is plain noise.
  task automatic random_frame();
    ppft_pkg::pkt_t             p [ppft_pkg::NSLOT];
    logic [ppft_pkg::NSLOT-1:0] flip;
    logic                       nf;
    int unsigned                r;
    if ($urandom_range(99) < 25) begin
      for (int s = 0; s < ppft_pkg::NSLOT; s++) p[s] = ppft_pkg::PKT_W'($urandom());
      flip = ppft_pkg::NSLOT'($urandom());
      nf   = 1'($urandom());
    end else begin
      for (int s = 0; s < ppft_pkg::NSLOT; s++) begin
        r = $urandom_range(99);
        if (r < 70) begin
          p[s] = mk_pkt(cur_target, 13'($urandom()),
                        ppft_pkg::HITS_W'($urandom_range(1, 255)));
        end else if (r < 80) begin
          p[s] = mk_pkt(ppft_pkg::BCID_W'($urandom()), 13'($urandom()), '0);
        end else if (r < 95 && cur_bound != '0) begin
          p[s] = mk_pkt(ppft_pkg::BCID_W'($urandom_range(0, cur_bound - 1)), 13'($urandom()),
                        ppft_pkg::HITS_W'($urandom_range(1, 255)));
        end else begin
          p[s] = mk_pkt(ppft_pkg::BCID_W'($urandom_range(cur_bound, 511)), 13'($urandom()),
                        ppft_pkg::HITS_W'($urandom_range(1, 255)));
        end
        flip[s] = ($urandom_range(99) < 15);
      end
      nf = ($urandom_range(99) < 20);
    end
    send_frame(nf, flip, p[0], p[1], p[2], p[3]);
  endtask

  // Watchdog: a run that hangs on a handshake or never drains ends here.
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [ppft_pkg::BCID_W-1:0] t;
    logic [ppft_pkg::BCID_W-1:0] w;
    logic [ppft_pkg::CHIP_W-1:0] c;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.new_file     = 1'b0;
    in_ch.parity_bits  = '0;
    in_ch.packet_slot0 = '0;
    in_ch.packet_slot1 = '0;
    in_ch.packet_slot2 = '0;
    in_ch.packet_slot3 = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    send_idle          = 19;
    recv_idle          = 77;
    cur_target         = '0;
    cur_bound          = ppft_pkg::TRAIN_WINDOW_RST;
    setting_cnt        = 1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in the reset setting: target 0, chip 0, bound 200.
    // Four kept packets with the widest address and hit pattern.
    send_frame(1'b0, 4'b0000, mk_pkt(9'd0, 13'h1fff, 8'hff), mk_pkt(9'd0, 13'h1fff, 8'hff),
               mk_pkt(9'd0, 13'h1fff, 8'hff), mk_pkt(9'd0, 13'h1fff, 8'hff));
    // All-zero frame: every packet is empty and nothing comes out.
    send_frame(1'b0, 4'b0000, '0, '0, '0, '0);
    // Parity failure, an empty packet at the top crossing that must not stop, another
    // crossing below the bound, then one good packet.
    send_frame(1'b0, 4'b1000, mk_pkt(9'd0, 13'h0000, 8'h01), mk_pkt(9'd511, 13'h1fff, 8'h00),
               mk_pkt(9'd5, 13'h0aaa, 8'h55), mk_pkt(9'd0, 13'h1555, 8'haa));
    // A crossing exactly at the bound stops the file after the first slot.
    send_frame(1'b0, 4'b0000, mk_pkt(9'd0, 13'h0123, 8'h0f), mk_pkt(9'd200, 13'h0000, 8'h01),
               mk_pkt(9'd0, 13'h0456, 8'h3c), mk_pkt(9'd0, 13'h0789, 8'hc3));
    // Still stopped: nothing comes out until a new file starts.
    send_frame(1'b0, 4'b0000, mk_pkt(9'd0, 13'h0001, 8'h11), mk_pkt(9'd0, 13'h0002, 8'h22),
               mk_pkt(9'd0, 13'h0003, 8'h33), mk_pkt(9'd0, 13'h0004, 8'h44));
    // New file clears the stop flag.
    send_frame(1'b1, 4'b0000, mk_pkt(9'd0, 13'h0aaa, 8'hf0), mk_pkt(9'd0, 13'h1555, 8'hf0),
               mk_pkt(9'd0, 13'h0f0f, 8'hf0), mk_pkt(9'd0, 13'h10f0, 8'hf0));
    // All-ones packets reach the bound at once, with and without a new file.
    send_frame(1'b0, 4'b0000, '1, '1, '1, '1);
    send_frame(1'b1, 4'b1111, '1, '1, '1, '1);
    // New file and every parity bit wrong: four failures.
    send_frame(1'b1, 4'b1111, mk_pkt(9'd0, 13'h0000, 8'h80), mk_pkt(9'd0, 13'h0000, 8'h80),
               mk_pkt(9'd0, 13'h0000, 8'h80), mk_pkt(9'd0, 13'h0000, 8'h80));
    // Crossing just under the bound is dropped without stopping.
    send_frame(1'b0, 4'b0000, mk_pkt(9'd199, 13'h0001, 8'h01), mk_pkt(9'd0, 13'h1fff, 8'hff),
               '0, '0);

    // Widest window and the highest regular chip: bound 511, tag of the last sensor.
    set_config(9'd0, 4'd11, 9'd511);
    send_frame(1'b0, 4'b0000, mk_pkt(9'd0, 13'h1fff, 8'hff), mk_pkt(9'd510, 13'h0001, 8'h01),
               mk_pkt(9'd0, 13'h0000, 8'h01), mk_pkt(9'd511, 13'h0000, 8'h01));
    send_frame(1'b1, 4'b0010, mk_pkt(9'd0, 13'h0abc, 8'h5a), mk_pkt(9'd0, 13'h1def, 8'ha5),
               mk_pkt(9'd0, 13'h0123, 8'h01), mk_pkt(9'd0, 13'h1fff, 8'h80));

    // Bound wraps to zero: every non-empty packet stops, an empty one does not.
    set_config(9'd312, 4'd12, 9'd200);
    send_frame(1'b1, 4'b0000, mk_pkt(9'd312, 13'h0001, 8'h00), mk_pkt(9'd312, 13'h0002, 8'h01),
               mk_pkt(9'd312, 13'h0003, 8'h01), '0);
    send_frame(1'b1, 4'b0000, mk_pkt(9'd0, 13'h0000, 8'h01), '0, '0, '0);

    // Highest target and zero window: the kept crossing is the bound itself.
    set_config(9'd511, 4'd15, 9'd0);
    send_frame(1'b1, 4'b0000, mk_pkt(9'd510, 13'h0000, 8'hff), mk_pkt(9'd511, 13'h1fff, 8'hff),
               '0, '0);

    // Out-of-range chip codes fold onto sensor 0 with the asic kept.
    set_config(9'd100, 4'd13, 9'd411);
    send_frame(1'b1, 4'b0101, mk_pkt(9'd100, 13'h1234, 8'h0f), mk_pkt(9'd100, 13'h0567, 8'hf0),
               mk_pkt(9'd100, 13'h089a, 8'h3c), mk_pkt(9'd100, 13'h1bcd, 8'hc3));
    set_config(9'd100, 4'd14, 9'd1);
    send_frame(1'b1, 4'b0000, mk_pkt(9'd100, 13'h0fff, 8'h77), mk_pkt(9'd101, 13'h0000, 8'h01),
               mk_pkt(9'd100, 13'h0001, 8'h01), '0);

    // Random part in six settings: the sender idles lightly and the receiver heavily, then
    // the other way round, then neither idles.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 19 : (ph < 4) ? 77 : 0;
      recv_idle = (ph < 2) ? 77 : (ph < 4) ? 19 : 0;
      t = ppft_pkg::BCID_W'($urandom_range(0, 480));
      w = ppft_pkg::BCID_W'($urandom_range(1, 511 - t));
      c = ppft_pkg::CHIP_W'($urandom_range(0, 15));
      set_config(t, c, w);
      for (int i = 0; i < 60; i++) begin
        // Once in the run the sender holds off until every result has come.
        if (ph == 1 && i == 30) wait_results_clear();
        random_frame();
      end
    end

    drain_block();

    $display("covered %0d frames giving %0d results, %0d of them parity failures,",
             frame_cnt, result_cnt, fail_cnt);
    $display("over %0d register settings and three idle patterns", setting_cnt);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
